// ===== hdl/stt_pkg.sv =====
// Shared types and constants for the software timer table.
// No dependencies; used by stt_table and software_timer_table_core.
`default_nettype none

package stt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W   = 32;
  localparam int TIME_W = 40;
  localparam int DLY_W  = 32;
  localparam int FIRE_W = 41;
  localparam int IVL_W  = 32;
  localparam int KIND_W = 3;

  typedef enum logic [1:0] {
    CMD_ADD        = 2'd0,
    CMD_CANCEL     = 2'd1,
    CMD_CANCEL_ALL = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGNED   = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_CANCEL_ACK = 3'd2,
    KIND_FIRED      = 3'd3,
    KIND_NONE       = 3'd4
  } kind_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [FIRE_W-1:0] fire;
    logic [IVL_W-1:0]  interval;
  } entry_t;

  // memory port control from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ram_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/stt_table.sv =====
// Entry memory of the timer table: one write port, one read port,
// registered read data held while rd_en is low. Depends on stt_pkg.
`default_nettype none

module stt_table (
  input  wire logic              clk,
  input  wire stt_pkg::ram_ctl_t ctl,
  input  wire stt_pkg::entry_t   wr_data,
  output stt_pkg::entry_t        rd_data
);

  stt_pkg::entry_t mem [stt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/software_timer_table_core.sv =====
// Add and cancel-all answer in the cycle after the transaction is accepted. Cancel-by-id
// and tick do one memory read, then visit one entry a cycle, then give one result; a tick
// stalls while a second fired id waits for the output. One command at a time: the next is
// taken once the final result has left.
// Reset (rst, synchronous, active high) empties the table and zeroes the id counter at once;
// entry memory keeps old contents and is never read beyond the live count, so no clearing pass.
`default_nettype none

module software_timer_table_core (
  input  wire logic         clk,
  input  wire logic         rst,
  // command stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // now_ms[39:0], delay_ms[71:40],
                                           // interval_ms[103:72], timer_id[135:104]
  input  wire logic [1:0]   s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // result_id[31:0]
  output logic [2:0]        m_axis_tuser,  // kind[2:0]
  output logic              m_axis_tlast   // last result of the command
);

  localparam int IDX_W  = stt_pkg::IDX_W;
  localparam int CNT_W  = stt_pkg::CNT_W;
  localparam int FIRE_W = stt_pkg::FIRE_W;

  // Logical index -> memory row. The live entries sit in a circular window
  // starting at base, oldest first.
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] b,
                                                input logic [CNT_W-1:0] lidx);
    logic [IDX_W:0] sum;
    sum = {1'b0, b} + {1'b0, lidx[IDX_W-1:0]};
    if (sum >= (IDX_W+1)'(stt_pkg::TABLE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(stt_pkg::TABLE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t                     state;
  logic [IDX_W-1:0]           base;
  logic [CNT_W-1:0]           cnt;
  logic [stt_pkg::ID_W-1:0]   next_id;
  stt_pkg::cmd_t              cmd_q;
  logic [stt_pkg::TIME_W-1:0] now_q;
  logic [stt_pkg::ID_W-1:0]   tid_q;
  logic [CNT_W-1:0]           rem;    // entries still to visit
  logic [CNT_W-1:0]           wpos;   // next kept entry goes to logical wpos-1
  logic                       pend_vld;
  logic [stt_pkg::ID_W-1:0]   pend_id;

  // unpacked command fields
  stt_pkg::cmd_t              in_cmd;
  logic [stt_pkg::TIME_W-1:0] in_now;
  logic [stt_pkg::DLY_W-1:0]  in_delay;
  logic [stt_pkg::IVL_W-1:0]  in_interval;
  logic [stt_pkg::ID_W-1:0]   in_tid;

  assign in_cmd      = stt_pkg::cmd_t'(s_axis_tuser);
  assign in_now      = s_axis_tdata[39:0];
  assign in_delay    = s_axis_tdata[71:40];
  assign in_interval = s_axis_tdata[103:72];
  assign in_tid      = s_axis_tdata[135:104];

  logic accept;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // entry memory
  stt_pkg::ram_ctl_t ram_ctl;
  stt_pkg::entry_t   wr_data;
  stt_pkg::entry_t   ent;

  stt_table u_table (
    .clk     (clk),
    .ctl     (ram_ctl),
    .wr_data (wr_data),
    .rd_data (ent)
  );

  // evaluate the entry now on the read port
  logic            fired;
  logic            drop;
  logic            out_free;
  logic            stall;
  logic            step;
  stt_pkg::entry_t upd;

  assign fired    = (cmd_q == stt_pkg::CMD_TICK) && ({1'b0, now_q} >= ent.fire);
  assign drop     = (cmd_q == stt_pkg::CMD_TICK) ? (fired && (ent.interval == '0))
                                                 : (ent.id == tid_q);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  // a second fired id must push the held one out first
  assign stall    = fired && pend_vld && !out_free;
  assign step     = (state == S_WALK) && !stall;

  always_comb begin
    upd = ent;
    if (fired) begin
      upd.fire = {1'b0, now_q} + FIRE_W'(ent.interval);
    end
  end

  // memory port: add writes at the tail; walk reads newest-first and writes
  // kept entries downward from the top, never onto a row not yet read
  always_comb begin
    ram_ctl = '0;
    wr_data = upd;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == stt_pkg::CMD_ADD && cnt != CNT_W'(stt_pkg::TABLE_DEPTH)) begin
            ram_ctl.wr_en    = 1'b1;
            ram_ctl.wr_addr  = phys_idx(base, cnt);
            wr_data.id       = next_id;
            wr_data.fire     = {1'b0, in_now} + FIRE_W'(in_delay);
            wr_data.interval = in_interval;
          end
          if ((in_cmd == stt_pkg::CMD_CANCEL || in_cmd == stt_pkg::CMD_TICK) &&
              cnt != '0) begin
            ram_ctl.rd_en   = 1'b1;
            ram_ctl.rd_addr = phys_idx(base, cnt - 1'b1);
          end
        end
      end
      S_WALK: begin
        if (step) begin
          if (!drop) begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = phys_idx(base, wpos - 1'b1);
          end
          if (rem > CNT_W'(1)) begin
            ram_ctl.rd_en   = 1'b1;
            ram_ctl.rd_addr = phys_idx(base, rem - CNT_W'(2));
          end
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, table bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      base          <= '0;
      cnt           <= '0;
      next_id       <= '0;
      pend_vld      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= in_cmd;
            now_q    <= in_now;
            tid_q    <= in_tid;
            rem      <= cnt;
            wpos     <= cnt;
            pend_vld <= 1'b0;
            case (in_cmd)
              stt_pkg::CMD_ADD: begin
                m_axis_tvalid <= 1'b1;
                m_axis_tlast  <= 1'b1;
                if (cnt == CNT_W'(stt_pkg::TABLE_DEPTH)) begin
                  m_axis_tuser <= stt_pkg::KIND_FULL;
                  m_axis_tdata <= '0;
                end else begin
                  m_axis_tuser <= stt_pkg::KIND_ASSIGNED;
                  m_axis_tdata <= next_id;
                  cnt          <= cnt + 1'b1;
                  next_id      <= next_id + 1'b1;
                end
              end
              stt_pkg::CMD_CANCEL_ALL: begin
                cnt           <= '0;
                m_axis_tvalid <= 1'b1;
                m_axis_tlast  <= 1'b1;
                m_axis_tuser  <= stt_pkg::KIND_CANCEL_ACK;
                m_axis_tdata  <= '0;
              end
              default: begin
                // cancel by id or tick
                if (cnt == '0) begin
                  m_axis_tvalid <= 1'b1;
                  m_axis_tlast  <= 1'b1;
                  if (in_cmd == stt_pkg::CMD_TICK) begin
                    m_axis_tuser <= stt_pkg::KIND_NONE;
                    m_axis_tdata <= '0;
                  end else begin
                    m_axis_tuser <= stt_pkg::KIND_CANCEL_ACK;
                    m_axis_tdata <= in_tid;
                  end
                end else begin
                  state <= S_WALK;
                end
              end
            endcase
          end
        end
        S_WALK: begin
          if (step) begin
            rem <= rem - 1'b1;
            if (!drop) begin
              wpos <= wpos - 1'b1;
            end
            if (fired) begin
              // hold newest fired id back so the final one can carry tlast
              if (pend_vld) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tlast  <= 1'b0;
                m_axis_tuser  <= stt_pkg::KIND_FIRED;
                m_axis_tdata  <= pend_id;
              end
              pend_vld <= 1'b1;
              pend_id  <= ent.id;
            end
            if (rem == CNT_W'(1)) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= 1'b1;
            if (cmd_q == stt_pkg::CMD_TICK) begin
              m_axis_tuser <= pend_vld ? stt_pkg::KIND_FIRED : stt_pkg::KIND_NONE;
              m_axis_tdata <= pend_vld ? pend_id : '0;
            end else begin
              m_axis_tuser <= stt_pkg::KIND_CANCEL_ACK;
              m_axis_tdata <= tid_q;
            end
            pend_vld <= 1'b0;
            // kept entries now sit at logical wpos..cnt-1
            cnt <= cnt - wpos;
            if (wpos != cnt) begin
              base <= phys_idx(base, wpos);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(stt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (wpos >= rem) && (rem != '0))
    else $error("compaction write would overtake the read pointer");

  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend_vld |-> (cmd_q == stt_pkg::CMD_TICK))
    else $error("held fired id outside a tick");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == stt_pkg::CMD_ADD && cnt != CNT_W'(stt_pkg::TABLE_DEPTH))
    |=> (cnt == $past(cnt) + 1'b1))
    else $error("add did not grow the table");
`endif

endmodule

`default_nettype wire
